FILE: hdl/ius_pkg.sv
`timescale 1ns / 1ps

package ius_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int OUT_W   = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IDX_W   = 2;
    localparam int TDATA_W = 32;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_INTERP_SELECT = 2'd2
    } t_cfg_reg;

    // One source pixel with its neighborhood, handed to the emitter
    typedef struct packed {
        logic [PIX_W-1:0] pix;       // current pixel
        logic [PIX_W-1:0] left;      // pixel to the left
        logic [PIX_W-1:0] up;        // pixel above
        logic [PIX_W-1:0] up_left;   // pixel above-left
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             has_left;  // col >= 1
        logic             last_col;
        logic             has_up;    // row >= 1
        logic             last_row;
        logic             interp;    // 1 average, 0 replicate
    } t_item;

endpackage

FILE: hdl/ius_row_mem.sv
`timescale 1ns / 1ps

// Single-port line buffer, read-first: the read returns the old entry
// while the same entry takes the new pixel.
module ius_row_mem
    import ius_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [COL_W-1:0] i_addr,
    input  logic [PIX_W-1:0] i_wr_data,
    output logic [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data      <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/ius_emit.sv
`timescale 1ns / 1ps

// Walks the output rows and column pairs of one source pixel, one word per
// cycle while the output stage is free, into a registered output stage.
module ius_emit
    import ius_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_item              i_item,
    output logic               o_free,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // tdata: out_pixel [7:0], out_row [18:8], out_col [29:19], zero [31:30]
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tlast
);

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
        return s[PIX_W:1];
    endfunction

    t_item            r_item;
    logic             r_e_valid;
    logic [1:0]       r_i;
    logic             r_k;
    logic             r_j;

    logic             r_o_valid;
    logic [TDATA_W-1:0] r_o_data;
    logic             r_o_last;

    logic             out_free;
    logic             step;
    logic             k_last;
    logic             i_last;
    logic             e_last;
    logic [1:0]       nr_m1;
    logic             use_left;
    logic             kind_up;
    logic [PIX_W-1:0] pa, pb, pua, pub;
    logic [COL_W-1:0] pc;
    logic [PIX_W-1:0] ev, od, pix_out;
    logic [OUT_W-1:0] row_base, row_out, col_out;

    // Sequencing
    assign out_free = !r_o_valid || i_m_axis_tready;
    assign step     = r_e_valid && out_free;
    assign k_last   = r_k || !(r_item.has_left && r_item.last_col);
    assign nr_m1    = r_item.interp ? (2'({1'b0, r_item.has_up}) + 2'({1'b0, r_item.last_row}))
                                    : 2'd1;
    assign i_last   = (r_i == nr_m1);
    assign e_last   = i_last && k_last && r_j;
    assign o_free   = !r_e_valid || (step && e_last);

    // Pair and row selection
    always_comb begin
        use_left = !r_k && r_item.has_left;
        pa       = use_left ? r_item.left    : r_item.pix;
        pb       = r_item.pix;
        pua      = use_left ? r_item.up_left : r_item.up;
        pub      = r_item.up;
        pc       = use_left ? (r_item.col - COL_W'(1)) : r_item.col;
        kind_up  = r_item.interp && r_item.has_up && (r_i == 2'd0);
        row_base = OUT_W'({r_item.row, 1'b0})
                 - OUT_W'(r_item.interp && r_item.has_up);
        row_out  = row_base + OUT_W'(r_i);
        col_out  = OUT_W'({pc, r_j});
    end

    // Pixel value
    always_comb begin
        if (!r_item.interp) begin
            ev = pa;
            od = pa;
        end else if (kind_up) begin
            ev = avg2(pua, pa);
            od = avg2(avg2(pua, pub), avg2(pa, pb));
        end else begin
            ev = pa;
            od = avg2(pa, pb);
        end
        pix_out = r_j ? od : ev;
    end

    // Item counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_i       <= 2'd0;
            r_k       <= 1'b0;
            r_j       <= 1'b0;
        end else if (i_load) begin
            r_e_valid <= 1'b1;
            r_i       <= 2'd0;
            r_k       <= 1'b0;
            r_j       <= 1'b0;
        end else if (step) begin
            if (e_last) begin
                r_e_valid <= 1'b0;
            end
            if (!r_j) begin
                r_j <= 1'b1;
            end else begin
                r_j <= 1'b0;
                if (k_last) begin
                    r_k <= 1'b0;
                    r_i <= r_i + 2'd1;
                end else begin
                    r_k <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (step) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_data <= {{(TDATA_W - PIX_W - 2 * OUT_W){1'b0}}, col_out, row_out, pix_out};
            r_o_last <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

endmodule

FILE: hdl/image_upscale_2x_average.sv
`timescale 1ns / 1ps
// The first output word of a pixel passes the stage 1, emitter item and output registers.
// Throughput: a pixel occupies the output port for 0 to 12 words (4 on average),
// one word per cycle while the output accepts; the output port sets the pixel rate.
// Reset (i_rst_n low, synchronous): counters and pipeline clear, width 640,
// height 480, average mode. The line buffer is not cleared.
module image_upscale_2x_average
    import ius_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // source pixels
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // tdata: src_pixel [7:0]
    input  logic [PIX_W-1:0]   i_s_axis_tdata,
    // upscaled pixels
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // tdata: out_pixel [7:0], out_row [18:8], out_col [29:19], zero [31:30]
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    // tlast: run_last
    output logic               o_m_axis_tlast
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             r_interp;

    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;

    // stage 1: pixel waiting on its line buffer read
    logic             r_s1_valid;
    t_item            r_s1;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_prev_up;

    logic [CFG_W-1:0] w_eff, h_eff;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic             last_col, last_row;
    logic             accept;
    logic             s1_consume;
    logic             s1_has_out;
    logic             emit_free;
    logic [PIX_W-1:0] up_data;
    t_item            load_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(480);
            r_interp <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_width  <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_height <= i_cfg_data;
                CFG_INTERP_SELECT: r_interp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective frame size and position of the incoming pixel
    always_comb begin
        if (r_width == '0)                     w_eff = CFG_W'(1);
        else if (r_width > CFG_W'(MAX_WIDTH))  w_eff = CFG_W'(MAX_WIDTH);
        else                                   w_eff = r_width;
        if (r_height == '0)                    h_eff = CFG_W'(1);
        else if (r_height > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
        else                                   h_eff = r_height;

        c = (CFG_W'(r_col_cnt) >= w_eff) ? COL_W'(w_eff - CFG_W'(1)) : r_col_cnt;
        r = (CFG_W'(r_row_cnt) >= h_eff) ? ROW_W'(h_eff - CFG_W'(1)) : r_row_cnt;
        last_col = (CFG_W'(c) + CFG_W'(1) >= w_eff);
        last_row = (CFG_W'(r) + CFG_W'(1) >= h_eff);
    end

    // Handshake
    assign s1_has_out      = r_s1.has_left || r_s1.last_col;
    assign s1_consume      = r_s1_valid && (!s1_has_out || emit_free);
    assign o_s_axis_tready = !r_s1_valid || s1_consume;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= last_row ? '0 : (r + ROW_W'(1));
            end else begin
                r_col_cnt <= c + COL_W'(1);
                r_row_cnt <= r;
            end
        end
    end

    // Line buffer: read the pixel above, store the current one
    ius_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_addr    (c),
        .i_wr_data (i_s_axis_tdata),
        .o_rd_data (up_data)
    );

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_left     <= i_s_axis_tdata;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pix      <= i_s_axis_tdata;
            r_s1.left     <= r_left;
            r_s1.up       <= '0;
            r_s1.up_left  <= '0;
            r_s1.col      <= c;
            r_s1.row      <= r;
            r_s1.has_left <= (c != '0);
            r_s1.last_col <= last_col;
            r_s1.has_up   <= (r != '0);
            r_s1.last_row <= last_row;
            r_s1.interp   <= r_interp;
        end
    end

    // Above-left pixel is the previous pixel's above pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_up <= '0;
        end else if (s1_consume) begin
            r_prev_up <= up_data;
        end
    end

    always_comb begin
        load_item         = r_s1;
        load_item.up      = up_data;
        load_item.up_left = r_prev_up;
    end

    ius_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_consume && s1_has_out),
        .i_item          (load_item),
        .o_free          (emit_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: verif/tb_image_upscale_2x_average.sv
`timescale 1ns / 1ps

module tb_image_upscale_2x_average;
    import ius_pkg::*;

    // How an output row is formed from the source neighborhood
    typedef enum logic [1:0] {
        ROW_SAME,   // even output row, and the bottom odd row: source row itself
        ROW_BLEND,  // odd output row between two source rows
        ROW_COPY    // replicate mode
    } t_row_kind;

    localparam logic MODE_REPLICATE = 1'b0;
    localparam logic MODE_AVERAGE   = 1'b1;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             last;
    } t_out_word;

    // Upscaler prediction and output word checking
    class upscale_scoreboard;
        logic [CFG_W-1:0] cfg_width;
        logic [CFG_W-1:0] cfg_height;
        logic             cfg_avg;
        logic [PIX_W-1:0] line_buf [MAX_WIDTH];
        bit               line_written [MAX_WIDTH];
        logic [PIX_W-1:0] left_pix;
        logic [PIX_W-1:0] up_left_pix;
        int unsigned      cur_row;
        int unsigned      cur_col;
        t_out_word        expected_words [$];
        int               errors;

        function new();
            cfg_width   = CFG_W'(640);
            cfg_height  = CFG_W'(480);
            cfg_avg     = MODE_AVERAGE;
            left_pix    = '0;
            up_left_pix = '0;
            cur_row     = 0;
            cur_col     = 0;
            errors      = 0;
            foreach (line_buf[i]) begin
                line_buf[i]     = '0;
                line_written[i] = 1'b0;
            end
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SOURCE_WIDTH:  cfg_width  = val;
                CFG_SOURCE_HEIGHT: cfg_height = val;
                CFG_INTERP_SELECT: cfg_avg    = val[0];
                default: ;
            endcase
        endfunction

        // Size in use: saturated to 1..hi
        function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return 32'(v);
        endfunction

        function logic [PIX_W-1:0] avg2(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            logic [PIX_W:0] s;
            s = {1'b0, x} + {1'b0, y} + {{PIX_W{1'b0}}, 1'b1};
            return s[PIX_W:1];
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // Pixels left until both counters wrap to zero
        function int unsigned pixels_to_frame_end();
            int unsigned w, h, c, r;
            w = eff_size(cfg_width, MAX_WIDTH);
            h = eff_size(cfg_height, MAX_HEIGHT);
            c = (cur_col >= w) ? w - 1 : cur_col;
            r = (cur_row >= h) ? h - 1 : cur_row;
            return (h - 1 - r) * w + (w - c);
        endfunction

        // A width change mid-frame must not expose line buffer entries never written
        function bit width_safe(logic [CFG_W-1:0] val);
            int unsigned n;
            n = eff_size(val, MAX_WIDTH);
            if (cur_row == 0) return 1'b1;
            for (int i = 0; i < n; i++)
                if (!line_written[i]) return 1'b0;
            return 1'b1;
        endfunction

        // Accepted source pixel: queue the output words it releases
        function void note_pixel(logic [PIX_W-1:0] p);
            int unsigned      w, h, c, r;
            bit               last_col, last_row;
            logic [PIX_W-1:0] up;
            int unsigned      n_cols, n_rows;
            int unsigned      col_idx [2];
            logic [PIX_W-1:0] a_pix [2];
            logic [PIX_W-1:0] b_pix [2];
            logic [PIX_W-1:0] ua_pix [2];
            logic [PIX_W-1:0] ub_pix [2];
            int unsigned      row_idx [3];
            t_row_kind        kinds [3];
            logic [PIX_W-1:0] even_pix, odd_pix;
            t_out_word        wd;

            w = eff_size(cfg_width, MAX_WIDTH);
            h = eff_size(cfg_height, MAX_HEIGHT);
            c = (cur_col >= w) ? w - 1 : cur_col;
            r = (cur_row >= h) ? h - 1 : cur_row;
            last_col = (c + 1 >= w);
            last_row = (r + 1 >= h);
            up = line_buf[c];

            // columns released: the previous one, and this one at row end
            n_cols = 0;
            if (c >= 1) begin
                col_idx[0] = c - 1;
                a_pix[0]   = left_pix;
                b_pix[0]   = p;
                ua_pix[0]  = up_left_pix;
                ub_pix[0]  = up;
                n_cols     = 1;
            end
            if (last_col) begin
                col_idx[n_cols] = c;
                a_pix[n_cols]   = p;
                b_pix[n_cols]   = p;
                ua_pix[n_cols]  = up;
                ub_pix[n_cols]  = up;
                n_cols++;
            end

            n_rows = 0;
            if (cfg_avg == MODE_AVERAGE) begin
                if (r >= 1) begin
                    row_idx[n_rows] = 2 * r - 1;
                    kinds[n_rows]   = ROW_BLEND;
                    n_rows++;
                end
                row_idx[n_rows] = 2 * r;
                kinds[n_rows]   = ROW_SAME;
                n_rows++;
                // bottom row copies the row above it
                if (last_row) begin
                    row_idx[n_rows] = 2 * r + 1;
                    kinds[n_rows]   = ROW_SAME;
                    n_rows++;
                end
            end else begin
                row_idx[0] = 2 * r;
                kinds[0]   = ROW_COPY;
                row_idx[1] = 2 * r + 1;
                kinds[1]   = ROW_COPY;
                n_rows     = 2;
            end

            for (int i = 0; i < n_rows; i++) begin
                for (int k = 0; k < n_cols; k++) begin
                    case (kinds[i])
                        ROW_SAME: begin
                            even_pix = a_pix[k];
                            odd_pix  = avg2(a_pix[k], b_pix[k]);
                        end
                        ROW_BLEND: begin
                            even_pix = avg2(ua_pix[k], a_pix[k]);
                            odd_pix  = avg2(avg2(ua_pix[k], ub_pix[k]),
                                            avg2(a_pix[k], b_pix[k]));
                        end
                        default: begin
                            even_pix = a_pix[k];
                            odd_pix  = a_pix[k];
                        end
                    endcase
                    wd.pixel = even_pix;
                    wd.row   = OUT_W'(row_idx[i]);
                    wd.col   = OUT_W'(2 * col_idx[k]);
                    wd.last  = 1'b0;
                    expected_words.push_back(wd);
                    wd.pixel = odd_pix;
                    wd.col   = OUT_W'(2 * col_idx[k] + 1);
                    wd.last  = (i == n_rows - 1) && (k == n_cols - 1);
                    expected_words.push_back(wd);
                end
            end

            line_buf[c]     = p;
            line_written[c] = 1'b1;
            up_left_pix     = up;
            left_pix        = p;
            if (last_col) begin
                cur_col = 0;
                cur_row = last_row ? 0 : r + 1;
            end else begin
                cur_col = c + 1;
                cur_row = r;
            end
        endfunction

        // Output word taken: compare with the oldest expectation
        function void check_word(logic [TDATA_W-1:0] data, logic last);
            t_out_word        e;
            logic [PIX_W-1:0] pix;
            logic [OUT_W-1:0] row, col;

            if (expected_words.size() == 0) begin
                errors++;
                $error("unexpected output word: tdata %h tlast %b", data, last);
                return;
            end
            e   = expected_words.pop_front();
            pix = data[PIX_W-1:0];
            row = data[PIX_W +: OUT_W];
            col = data[PIX_W+OUT_W +: OUT_W];
            if (pix !== e.pixel) begin
                errors++;
                $error("out_pixel: expected %0d, actual %0d", e.pixel, pix);
            end
            if (row !== e.row) begin
                errors++;
                $error("out_row: expected %0d, actual %0d", e.row, row);
            end
            if (col !== e.col) begin
                errors++;
                $error("out_col: expected %0d, actual %0d", e.col, col);
            end
            if (last !== e.last) begin
                errors++;
                $error("run_last: expected %0d, actual %0d", e.last, last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    t_cfg_reg           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [PIX_W-1:0]   i_s_axis_tdata;    // src_pixel
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;    // out_pixel, out_row, out_col, zero fill
    logic               o_m_axis_tlast;    // run_last

    upscale_scoreboard  sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int unsigned        pixels_sent;

    image_upscale_2x_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Pixel values leaning toward the range ends
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_size(int unsigned hi);
        if ($urandom_range(9) == 0) return '0;
        return CFG_W'($urandom_range(hi, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the handshake
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(rand_pixel());
    endtask

    // Extremes and rounding corners: 0+255 and 1+254 round up
    task automatic send_pattern(input int unsigned count);
        logic [PIX_W-1:0] pat [6];
        pat = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
        for (int unsigned i = 0; i < count; i++)
            send_pixel(pat[i % 6]);
    endtask

    // Hold off until every expected word is out, plus the pipeline depth
    task automatic wait_idle();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] mode);
        wait_idle();
        write_reg(CFG_SOURCE_WIDTH, w);
        write_reg(CFG_SOURCE_HEIGHT, h);
        write_reg(CFG_INTERP_SELECT, mode);
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] mode);
        set_frame(w, h, mode);
        send_run(sb.pixels_to_frame_end());
    endtask

    // Small random frame; sometimes the size or mode changes partway through
    task automatic random_frame();
        logic [CFG_W-1:0] nw;
        int unsigned      total, part;
        set_frame(rand_size(10), rand_size(5), CFG_W'($urandom_range(1)));
        total = sb.pixels_to_frame_end();
        if (total > 1 && $urandom_range(3) == 0) begin
            part = $urandom_range(total - 1, 1);
            send_run(part);
            wait_idle();
            nw = rand_size(10);
            if (!sb.width_safe(nw))
                nw = 11'd1;
            write_reg(CFG_SOURCE_WIDTH, nw);
            write_reg(CFG_SOURCE_HEIGHT, rand_size(5));
            if ($urandom_range(1))
                write_reg(CFG_INTERP_SELECT, CFG_W'($urandom_range(1)));
            send_run(sb.pixels_to_frame_end());
        end else begin
            send_run(total);
        end
    endtask

    initial begin
        int unsigned start_count;
        sb              = new();
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_SOURCE_WIDTH;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 13;
        recv_idle_pct   = 55;
        pixels_sent     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: small frames in both modes, saturated sizes, single column
        set_frame(11'd3, 11'd2, CFG_W'(MODE_AVERAGE));
        send_pattern(6);
        set_frame(11'd2, 11'd2, 11'h7FE);       // only bit 0 counts: replicate
        send_pattern(4);
        set_frame(11'd0, 11'd0, CFG_W'(MODE_AVERAGE));  // 1x1 frames
        send_pattern(2);
        set_frame(11'd1, 11'd3, CFG_W'(MODE_AVERAGE));
        send_pattern(3);
        // shrink mid-frame: the row counter, past the new height, acts as last position
        set_frame(11'd4, 11'd3, CFG_W'(MODE_AVERAGE));
        send_pattern(5);
        wait_idle();
        write_reg(CFG_SOURCE_WIDTH, 11'd2);
        write_reg(CFG_SOURCE_HEIGHT, 11'd1);
        send_pattern(sb.pixels_to_frame_end());

        // random: sender idles lightly, receiver heavily, then swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 13 : 0;
            start_count   = pixels_sent;
            while (pixels_sent - start_count < 110)
                random_frame();
        end

        // a long single row and a tall single column
        run_frame(11'd24, 11'd1, CFG_W'(MODE_REPLICATE));
        run_frame(11'd1, 11'd12, CFG_W'(MODE_AVERAGE));

        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ius_pkg.sv
hdl/ius_row_mem.sv
hdl/ius_emit.sv
hdl/image_upscale_2x_average.sv
verif/tb_image_upscale_2x_average.sv
